FILE: rtl/rhsv_pkg.sv
// rhsv_pkg: shared types and constants for the rgb to hsv pixel converter
// no dependencies; used by every module under rtl

package rhsv_pkg;

  // field widths
  localparam int BYTE_W = 8;
  localparam int HUE_W  = 15;
  localparam int SAT_W  = 17;

  // hue numerator before the fractional shift: below 360 * 255
  localparam int NUM_W  = 17;
  // sector coefficient up to 360
  localparam int COEF_W = 9;
  // quotient bits that hold the integer part of the hue (0..359)
  localparam int HUE_INT_BITS = 9;

  // default fixed-point formats
  localparam int HUE_FRAC_BITS_DEF = 6;
  localparam int SAT_FRAC_BITS_DEF = 16;

  // angle constants in degrees
  localparam int DEG_PER_SECTOR = 60;
  localparam int GREEN_OFFSET   = 2;
  localparam int BLUE_OFFSET    = 4;
  localparam int FULL_TURN      = 360;

  // which channel holds the maximum
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // per-pixel flags and value that ride alongside the dividers
  typedef struct packed {
    logic              gray;   // delta is zero, hue forced to zero
    logic              black;  // max is zero, saturation forced to zero
    logic [BYTE_W-1:0] bright; // largest channel
  } ctl_t;

endpackage

FILE: rtl/rhsv_prep.sv
// rhsv_prep: three-stage front end, max/min, sector select and hue numerator
// depends on rhsv_pkg

module rhsv_prep (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rhsv_pkg::BYTE_W-1:0]  red,
  input  logic [rhsv_pkg::BYTE_W-1:0]  green,
  input  logic [rhsv_pkg::BYTE_W-1:0]  blue,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rhsv_pkg::NUM_W-1:0]   out_num,
  output logic [rhsv_pkg::BYTE_W-1:0]  out_delta,
  output rhsv_pkg::ctl_t               out_ctl
);

  localparam int BW = rhsv_pkg::BYTE_W;
  localparam int CW = rhsv_pkg::COEF_W;
  localparam int DW = BW + 1;     // signed channel difference
  localparam int SW = 19;         // signed numerator sum

  logic adv;

  // stage 1 registers
  logic                s1_valid_r;
  logic [BW-1:0]       s1_red_r, s1_green_r, s1_blue_r, s1_max_r, s1_min_r;
  rhsv_pkg::sector_t   s1_sec_r;
  logic [BW-1:0]       s1_max_nxt, s1_min_nxt;
  rhsv_pkg::sector_t   s1_sec_nxt;

  // stage 2 registers
  logic                s2_valid_r;
  logic [BW-1:0]       s2_delta_r;
  logic [CW-1:0]       s2_coef_r;
  logic signed [DW-1:0] s2_diff_r;
  rhsv_pkg::ctl_t      s2_ctl_r;
  logic [CW-1:0]       s2_coef_nxt;
  logic signed [DW-1:0] s2_diff_nxt;

  // stage 3 registers
  logic                s3_valid_r;
  logic [rhsv_pkg::NUM_W-1:0] s3_num_r;
  logic [BW-1:0]       s3_delta_r;
  rhsv_pkg::ctl_t      s3_ctl_r;
  logic signed [SW-1:0] s3_sum_nxt;

  // whole front end moves together unless the last stage is held
  assign adv      = !s3_valid_r || out_ready;
  assign in_ready = adv;

  // max, min and the winning sector, red wins ties then green
  always_comb begin
    s1_max_nxt = red;
    if (green > s1_max_nxt) s1_max_nxt = green;
    if (blue > s1_max_nxt) s1_max_nxt = blue;
    s1_min_nxt = red;
    if (green < s1_min_nxt) s1_min_nxt = green;
    if (blue < s1_min_nxt) s1_min_nxt = blue;
    if (s1_max_nxt == red) begin
      s1_sec_nxt = rhsv_pkg::SEC_RED;
    end else if (s1_max_nxt == green) begin
      s1_sec_nxt = rhsv_pkg::SEC_GREEN;
    end else begin
      s1_sec_nxt = rhsv_pkg::SEC_BLUE;
    end
  end

  // sector offset and signed channel difference
  always_comb begin
    s2_coef_nxt = '0;
    s2_diff_nxt = '0;
    case (s1_sec_r)
      rhsv_pkg::SEC_RED: begin
        s2_diff_nxt = $signed({1'b0, s1_green_r}) - $signed({1'b0, s1_blue_r});
        s2_coef_nxt = (s1_green_r >= s1_blue_r) ? '0 : CW'(rhsv_pkg::FULL_TURN);
      end
      rhsv_pkg::SEC_GREEN: begin
        s2_diff_nxt = $signed({1'b0, s1_blue_r}) - $signed({1'b0, s1_red_r});
        s2_coef_nxt = CW'(rhsv_pkg::DEG_PER_SECTOR * rhsv_pkg::GREEN_OFFSET);
      end
      rhsv_pkg::SEC_BLUE: begin
        s2_diff_nxt = $signed({1'b0, s1_red_r}) - $signed({1'b0, s1_green_r});
        s2_coef_nxt = CW'(rhsv_pkg::DEG_PER_SECTOR * rhsv_pkg::BLUE_OFFSET);
      end
      default: begin
        s2_diff_nxt = '0;
        s2_coef_nxt = '0;
      end
    endcase
  end

  // numerator: offset times delta plus sixty times the difference
  always_comb begin
    s3_sum_nxt = $signed({2'b00, CW'(s2_coef_r) * (CW + BW)'(s2_delta_r)})
               + $signed({{(SW - DW){s2_diff_r[DW-1]}}, s2_diff_r})
                 * $signed(SW'(rhsv_pkg::DEG_PER_SECTOR));
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_red_r        <= red;
      s1_green_r      <= green;
      s1_blue_r       <= blue;
      s1_max_r        <= s1_max_nxt;
      s1_min_r        <= s1_min_nxt;
      s1_sec_r        <= s1_sec_nxt;
      s2_delta_r      <= s1_max_r - s1_min_r;
      s2_coef_r       <= s2_coef_nxt;
      s2_diff_r       <= s2_diff_nxt;
      s2_ctl_r.gray   <= (s1_max_r == s1_min_r);
      s2_ctl_r.black  <= (s1_max_r == '0);
      s2_ctl_r.bright <= s1_max_r;
      s3_num_r        <= s3_sum_nxt[rhsv_pkg::NUM_W-1:0];
      s3_delta_r      <= s2_delta_r;
      s3_ctl_r        <= s2_ctl_r;
    end
  end

  assign out_valid = s3_valid_r;
  assign out_num   = s3_num_r;
  assign out_delta = s3_delta_r;
  assign out_ctl   = s3_ctl_r;

endmodule

FILE: rtl/rhsv_div.sv
// rhsv_div: pipelined restoring dividers for hue and saturation, one bit a stage
// depends on rhsv_pkg

module rhsv_div #(
  parameter int HUE_FRAC_BITS = rhsv_pkg::HUE_FRAC_BITS_DEF,
  parameter int SAT_FRAC_BITS = rhsv_pkg::SAT_FRAC_BITS_DEF,
  parameter int STEPS = ((HUE_FRAC_BITS + rhsv_pkg::HUE_INT_BITS) > (SAT_FRAC_BITS + 1))
                        ? (HUE_FRAC_BITS + rhsv_pkg::HUE_INT_BITS) : (SAT_FRAC_BITS + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rhsv_pkg::NUM_W-1:0]  in_num,
  input  logic [rhsv_pkg::BYTE_W-1:0] in_delta,
  input  rhsv_pkg::ctl_t              in_ctl,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [STEPS-1:0]            out_hue_quo,
  output logic [STEPS-1:0]            out_sat_quo,
  output rhsv_pkg::ctl_t              out_ctl
);

  localparam int BW = rhsv_pkg::BYTE_W;
  localparam int XW = STEPS + BW;   // widened dividend

  logic adv;
  logic [XW-1:0] hue_ext, sat_ext;

  // per-stage inputs (from the port or the stage before)
  logic [BW-1:0]    cur_hrem [STEPS];
  logic [STEPS-1:0] cur_hdq  [STEPS];
  logic [BW-1:0]    cur_srem [STEPS];
  logic [STEPS-1:0] cur_sdq  [STEPS];
  logic [BW-1:0]    cur_dlt  [STEPS];
  rhsv_pkg::ctl_t   cur_ctl  [STEPS];

  // per-stage next values
  logic [BW-1:0]    hrem_nxt [STEPS];
  logic [STEPS-1:0] hdq_nxt  [STEPS];
  logic [BW-1:0]    srem_nxt [STEPS];
  logic [STEPS-1:0] sdq_nxt  [STEPS];

  // stage registers
  logic [STEPS-1:0] vld_r;
  logic [BW-1:0]    hrem_r [STEPS];
  logic [STEPS-1:0] hdq_r  [STEPS];
  logic [BW-1:0]    srem_r [STEPS];
  logic [STEPS-1:0] sdq_r  [STEPS];
  logic [BW-1:0]    dlt_r  [STEPS];
  rhsv_pkg::ctl_t   ctl_r  [STEPS];

  // pipeline moves as a whole unless the last stage is held
  assign adv      = !vld_r[STEPS-1] || out_ready;
  assign in_ready = adv;

  // dividends with fraction bits appended; quotients fit in STEPS bits
  assign hue_ext = XW'(in_num) << HUE_FRAC_BITS;
  assign sat_ext = XW'(in_delta) << SAT_FRAC_BITS;

  // stage inputs
  always_comb begin
    cur_hrem[0] = hue_ext[XW-1:STEPS];
    cur_hdq[0]  = hue_ext[STEPS-1:0];
    cur_srem[0] = sat_ext[XW-1:STEPS];
    cur_sdq[0]  = sat_ext[STEPS-1:0];
    cur_dlt[0]  = in_delta;
    cur_ctl[0]  = in_ctl;
    for (int k = 1; k < STEPS; k++) begin
      cur_hrem[k] = hrem_r[k-1];
      cur_hdq[k]  = hdq_r[k-1];
      cur_srem[k] = srem_r[k-1];
      cur_sdq[k]  = sdq_r[k-1];
      cur_dlt[k]  = dlt_r[k-1];
      cur_ctl[k]  = ctl_r[k-1];
    end
  end

  // one restoring step per stage: hue divides by delta, saturation by max
  always_comb begin
    logic [BW:0] htry, stry;
    for (int k = 0; k < STEPS; k++) begin
      htry = {cur_hrem[k], cur_hdq[k][STEPS-1]};
      if (htry >= {1'b0, cur_dlt[k]}) begin
        hrem_nxt[k] = BW'(htry - {1'b0, cur_dlt[k]});
        hdq_nxt[k]  = {cur_hdq[k][STEPS-2:0], 1'b1};
      end else begin
        hrem_nxt[k] = htry[BW-1:0];
        hdq_nxt[k]  = {cur_hdq[k][STEPS-2:0], 1'b0};
      end
      stry = {cur_srem[k], cur_sdq[k][STEPS-1]};
      if (stry >= {1'b0, cur_ctl[k].bright}) begin
        srem_nxt[k] = BW'(stry - {1'b0, cur_ctl[k].bright});
        sdq_nxt[k]  = {cur_sdq[k][STEPS-2:0], 1'b1};
      end else begin
        srem_nxt[k] = stry[BW-1:0];
        sdq_nxt[k]  = {cur_sdq[k][STEPS-2:0], 1'b0};
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[STEPS-2:0], in_valid};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < STEPS; k++) begin
        hrem_r[k] <= hrem_nxt[k];
        hdq_r[k]  <= hdq_nxt[k];
        srem_r[k] <= srem_nxt[k];
        sdq_r[k]  <= sdq_nxt[k];
        dlt_r[k]  <= cur_dlt[k];
        ctl_r[k]  <= cur_ctl[k];
      end
    end
  end

  assign out_valid   = vld_r[STEPS-1];
  assign out_hue_quo = hdq_r[STEPS-1];
  assign out_sat_quo = sdq_r[STEPS-1];
  assign out_ctl     = ctl_r[STEPS-1];

endmodule

FILE: rtl/rgb_to_hsv_pixel_convert.sv
// rgb_to_hsv_pixel_convert: top level of the rgb to hsv pixel converter
// depends on rhsv_pkg, rhsv_prep and rhsv_div
//
//   channel   dir  payload (low bit first)                       handshake
//   in_       in   red[7:0] green[15:8] blue[23:16]               tvalid/tready
//   out_      out  hue[14:0] saturation[31:15] brightness[39:32]  tvalid/tready
//
// one pixel per cycle sustained while out_tready is high; a pixel passes the rhsv_prep stages,
// then STEPS = max(HUE_FRAC_BITS + 9, SAT_FRAC_BITS + 1) divider stages (17 by default), then the output register
// each divider stage resolves one quotient bit of both the hue and saturation
// synchronous active-low reset clears the valid bits only
// a stall on out_tready holds every stage; nothing is dropped or repeated

module rgb_to_hsv_pixel_convert #(
  parameter int HUE_FRAC_BITS = rhsv_pkg::HUE_FRAC_BITS_DEF,
  parameter int SAT_FRAC_BITS = rhsv_pkg::SAT_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // hue[14:0], saturation[31:15], brightness[39:32]
);

  localparam int BW = rhsv_pkg::BYTE_W;
  localparam int HW = rhsv_pkg::HUE_W;
  localparam int SW = rhsv_pkg::SAT_W;
  localparam int STEPS = ((HUE_FRAC_BITS + rhsv_pkg::HUE_INT_BITS) > (SAT_FRAC_BITS + 1))
                         ? (HUE_FRAC_BITS + rhsv_pkg::HUE_INT_BITS) : (SAT_FRAC_BITS + 1);

  logic                       prep_valid, prep_ready;
  logic [rhsv_pkg::NUM_W-1:0] prep_num;
  logic [BW-1:0]              prep_delta;
  rhsv_pkg::ctl_t             prep_ctl;

  logic                       div_valid, div_ready;
  logic [STEPS-1:0]           div_hue_quo, div_sat_quo;
  rhsv_pkg::ctl_t             div_ctl;

  logic                       out_valid_r;
  logic [HW-1:0]              hue_r, hue_nxt;
  logic [SW-1:0]              sat_r, sat_nxt;
  logic [BW-1:0]              bright_r;

  // max/min, sector and hue numerator
  rhsv_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .red       (in_tdata[7:0]),
    .green     (in_tdata[15:8]),
    .blue      (in_tdata[23:16]),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_num   (prep_num),
    .out_delta (prep_delta),
    .out_ctl   (prep_ctl)
  );

  // hue and saturation quotients
  rhsv_div #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .SAT_FRAC_BITS (SAT_FRAC_BITS),
    .STEPS         (STEPS)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (prep_valid),
    .in_ready    (prep_ready),
    .in_num      (prep_num),
    .in_delta    (prep_delta),
    .in_ctl      (prep_ctl),
    .out_valid   (div_valid),
    .out_ready   (div_ready),
    .out_hue_quo (div_hue_quo),
    .out_sat_quo (div_sat_quo),
    .out_ctl     (div_ctl)
  );

  // gray and black pixels override the quotients, then fit to field width
  always_comb begin
    hue_nxt = div_ctl.gray  ? '0 : HW'(div_hue_quo);
    sat_nxt = div_ctl.black ? '0 : SW'(div_sat_quo);
  end

  // output register
  assign div_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_ready) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready) begin
      hue_r    <= hue_nxt;
      sat_r    <= sat_nxt;
      bright_r <= div_ctl.bright;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {bright_r, sat_r, hue_r};

endmodule

FILE: verif/tb_rgb_to_hsv_pixel_convert.sv
// tb_rgb_to_hsv_pixel_convert: self-checking testbench for the rgb to hsv pixel converter
// depends on rhsv_pkg and rgb_to_hsv_pixel_convert; predicts each hsv result in line
// and compares it field by field, under idle, stall and long output hold traffic

module tb_rgb_to_hsv_pixel_convert;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HUE_FRAC    = rhsv_pkg::HUE_FRAC_BITS_DEF;
  localparam int SAT_FRAC    = rhsv_pkg::SAT_FRAC_BITS_DEF;
  localparam int DIV_STEPS   = (HUE_FRAC + rhsv_pkg::HUE_INT_BITS > SAT_FRAC + 1)
                               ? HUE_FRAC + rhsv_pkg::HUE_INT_BITS : SAT_FRAC + 1;
  localparam int LATENCY     = 3 + DIV_STEPS + 1;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int EXP_DEPTH   = 4096;

  // payload layouts, lowest field in the lowest bits
  typedef struct packed {
    logic [rhsv_pkg::BYTE_W-1:0] blue;
    logic [rhsv_pkg::BYTE_W-1:0] green;
    logic [rhsv_pkg::BYTE_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [rhsv_pkg::BYTE_W-1:0] brightness;
    logic [rhsv_pkg::SAT_W-1:0]  saturation;
    logic [rhsv_pkg::HUE_W-1:0]  hue;
  } hsv_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // red[7:0], green[15:8], blue[23:16]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // hue[14:0], saturation[31:15], brightness[39:32]

  // expected results in request order, indexed by running counts
  hsv_t exp_mem [EXP_DEPTH];
  int   exp_wr;
  int   exp_rd;
  int   mismatch_count;
  int   tx_idle_pct;
  int   rx_stall_pct;
  int   hold_epoch;
  int   cycle_count;

  rgb_to_hsv_pixel_convert #(
    .HUE_FRAC_BITS(HUE_FRAC),
    .SAT_FRAC_BITS(SAT_FRAC)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // expected hsv for one pixel, exact integer math on the channel bytes
  function automatic hsv_t hsv_of(input pixel_t px);
    logic [63:0] r, g, b, mx, mn, delta, num, sat;
    hsv_t res;
    r  = px.red;
    g  = px.green;
    b  = px.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    // black pixel keeps zero saturation
    if (mx == 0) sat = 0;
    else sat = (delta << SAT_FRAC) / mx;
    // sector order on ties: red, then green, then blue
    if (delta == 0) num = 0;
    else if (mx == r) begin
      if (g >= b) num = rhsv_pkg::DEG_PER_SECTOR * (g - b);
      else num = rhsv_pkg::FULL_TURN * delta - rhsv_pkg::DEG_PER_SECTOR * (b - g);
    end else if (mx == g) begin
      num = rhsv_pkg::DEG_PER_SECTOR * rhsv_pkg::GREEN_OFFSET * delta
          + rhsv_pkg::DEG_PER_SECTOR * b - rhsv_pkg::DEG_PER_SECTOR * r;
    end else begin
      num = rhsv_pkg::DEG_PER_SECTOR * rhsv_pkg::BLUE_OFFSET * delta
          + rhsv_pkg::DEG_PER_SECTOR * r - rhsv_pkg::DEG_PER_SECTOR * g;
    end
    // gray pixel has hue zero
    if (delta == 0) res.hue = '0;
    else res.hue = rhsv_pkg::HUE_W'((num << HUE_FRAC) / delta);
    res.saturation = rhsv_pkg::SAT_W'(sat);
    res.brightness = rhsv_pkg::BYTE_W'(mx);
    return res;
  endfunction

  function automatic pixel_t rgb(input int r, input int g, input int b);
    pixel_t px;
    px.red   = rhsv_pkg::BYTE_W'(r);
    px.green = rhsv_pkg::BYTE_W'(g);
    px.blue  = rhsv_pkg::BYTE_W'(b);
    return px;
  endfunction

  // random pixel, weighted toward grays, ties and small deltas
  function automatic pixel_t random_pixel();
    pixel_t px;
    int     v, lo, sel;
    px = pixel_t'(24'($urandom));
    case ($urandom_range(0, 9))
      0: begin
        v  = $urandom_range(0, 255);
        px = rgb(v, v, v);
      end
      1: begin
        v   = $urandom_range(1, 255);
        lo  = $urandom_range(0, v - 1);
        sel = $urandom_range(0, 2);
        px  = rgb(sel == 0 ? lo : v, sel == 1 ? lo : v, sel == 2 ? lo : v);
      end
      2: begin
        v  = $urandom_range(0, 251);
        px = rgb(v + $urandom_range(0, 4), v + $urandom_range(0, 4), v + $urandom_range(0, 4));
      end
      3: begin
        sel = $urandom_range(0, 2);
        v   = $urandom_range(0, 1) ? 255 : 0;
        if (sel == 0) px.red = rhsv_pkg::BYTE_W'(v);
        else if (sel == 1) px.green = rhsv_pkg::BYTE_W'(v);
        else px.blue = rhsv_pkg::BYTE_W'(v);
      end
      default: ;
    endcase
    return px;
  endfunction

  // drive one request and wait for it to be taken
  task automatic send_pixel(input pixel_t px);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop sending and let every expected result come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (exp_rd != exp_wr) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // primaries, secondaries, grays, ties and the red sector wraparound
  task automatic test_reference_colors();
    pixel_t colors[$];
    colors = '{rgb(0, 0, 0), rgb(255, 255, 255), rgb(128, 128, 128), rgb(1, 1, 1),
               rgb(255, 0, 0), rgb(0, 255, 0), rgb(0, 0, 255),
               rgb(255, 255, 0), rgb(0, 255, 255), rgb(255, 0, 255), rgb(9, 9, 3),
               rgb(255, 0, 1), rgb(255, 1, 0), rgb(200, 100, 150), rgb(100, 200, 50),
               rgb(50, 100, 200), rgb(1, 0, 0), rgb(0, 1, 0), rgb(0, 0, 1),
               rgb(255, 254, 254), rgb(1, 0, 255), rgb(170, 85, 0), rgb(254, 255, 0)};
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    foreach (colors[i]) send_pixel(colors[i]);
    drain_results();
  endtask

  // random pixels under a given sender idle and receiver stall rate
  task automatic test_random_pixels(input int count, input int idle_pct, input int stall_pct);
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    repeat (count) send_pixel(random_pixel());
    drain_results();
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_output_hold();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_epoch++;
    repeat (120) send_pixel(random_pixel());
    drain_results();
  endtask

  // receiver: random stalls plus an occasional long hold
  initial begin : receiver
    int seen_epoch;
    int hold_left;
    seen_epoch = 0;
    hold_left  = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_epoch != seen_epoch) begin
        seen_epoch = hold_epoch;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // record accepted pixels and check every returned result
  always @(posedge clk) begin : check_results
    hsv_t got, want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        exp_mem[exp_wr[11:0]] = hsv_of(pixel_t'(in_tdata));
        exp_wr++;
      end
      if (out_tvalid && out_tready) begin
        got = hsv_t'(out_tdata);
        if (exp_rd == exp_wr) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result hue=%0d sat=%0d val=%0d",
                     got.hue, got.saturation, got.brightness);
        end else begin
          want = exp_mem[exp_rd[11:0]];
          exp_rd++;
          if (got.hue !== want.hue || got.saturation !== want.saturation ||
              got.brightness !== want.brightness) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("mismatch hue exp %0d got %0d, sat exp %0d got %0d, val exp %0d got %0d",
                       want.hue, got.hue, want.saturation, got.saturation,
                       want.brightness, got.brightness);
          end
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // test sequence
  initial begin
    mismatch_count = 0;
    exp_wr         = 0;
    exp_rd         = 0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    hold_epoch     = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reference_colors();
    test_random_pixels(400, 0, 0);
    test_random_pixels(350, 76, 0);
    test_random_pixels(350, 0, 76);
    test_random_pixels(300, 16, 16);
    test_output_hold();

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/rhsv_pkg.sv
rtl/rhsv_prep.sv
rtl/rhsv_div.sv
rtl/rgb_to_hsv_pixel_convert.sv
verif/tb_rgb_to_hsv_pixel_convert.sv
